[design/gnt_pkg.sv]
// Shared constants, types and small tables for the goniometer nudge transform.
// Used by gnt_seq and goniometer_nudge_transform_core.
`timescale 1ns / 1ps
`default_nettype none

package gnt_pkg;

    // PI_Q30 = 45 * PI_DIV45 + 26; PI_REM_RCP = 26 * ceil(2^32 / 45)
    localparam logic [26:0] PI_DIV45   = 27'd74961320;
    localparam logic [31:0] PI_REM_RCP = 32'd2481536668;
    localparam logic [17:0] X_RND      = 18'd131072;
    localparam logic [22:0] D90       = 23'd5898240;
    localparam logic [22:0] D45       = 23'd2949120;
    localparam logic [32:0] RED_OFS   = 33'd3019898880;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30  = 30'h2000_0000;
    localparam logic [4:0]  RED_STEPS = 5'd9;
    localparam logic [3:0]  HK_SIN_LAST = 4'd4;
    localparam logic [3:0]  HK_COS_LAST = 4'd10;

    localparam logic [1:0] REG_OMEGA_OFFSET = 2'd0;
    localparam logic [1:0] REG_TWEAK_X      = 2'd1;
    localparam logic [1:0] REG_TWEAK_Y      = 2'd2;
    localparam logic [1:0] REG_TWEAK_Z      = 2'd3;

    localparam logic [1:0] MODE_SET_POSE     = 2'd0;
    localparam logic [1:0] MODE_SET_OMEGA    = 2'd1;
    localparam logic [1:0] MODE_NUDGE_HOLDER = 2'd2;
    localparam logic [1:0] MODE_NUDGE_ORIGIN = 2'd3;

    localparam logic [2:0] ROT_TWEAK_X = 3'd0;
    localparam logic [2:0] ROT_TWEAK_Y = 3'd1;
    localparam logic [2:0] ROT_TWEAK_Z = 3'd2;
    localparam logic [2:0] ROT_OMEGA   = 3'd3;
    localparam logic [2:0] ROT_CHI     = 3'd4;
    localparam logic [2:0] ROT_PHI     = 3'd5;

    typedef struct packed {
        logic signed [32:0] tweak_x;
        logic signed [32:0] tweak_y;
        logic signed [32:0] tweak_z;
        logic signed [32:0] omega;
        logic signed [32:0] chi;
        logic signed [32:0] phi;
    } gnt_ang_t;

    typedef struct packed {
        logic start;
        logic to_origin;
        logic ack;
    } gnt_cmd_t;

    function automatic logic [7:0] horner_div(input logic [3:0] hk);
        logic [7:0] d;
        case (hk)
            4'd0:    d = 8'd110;
            4'd1:    d = 8'd72;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd20;
            4'd4:    d = 8'd6;
            4'd5:    d = 8'd132;
            4'd6:    d = 8'd90;
            4'd7:    d = 8'd56;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^30 / divisor)
    function automatic logic [29:0] horner_recip(input logic [3:0] hk);
        logic [29:0] m;
        case (hk)
            4'd0:    m = 30'd9761289;
            4'd1:    m = 30'd14913080;
            4'd2:    m = 30'd25565281;
            4'd3:    m = 30'd53687091;
            4'd4:    m = 30'd178956970;
            4'd5:    m = 30'd8134407;
            4'd6:    m = 30'd11930464;
            4'd7:    m = 30'd19173961;
            4'd8:    m = 30'd35791394;
            4'd9:    m = 30'd89478485;
            default: m = 30'd536870912;
        endcase
        return m;
    endfunction

    function automatic logic [32:0] red_div(input logic [3:0] k);
        return {10'd0, D90} << k;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/gnt_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing beyond the clock; operands come from gnt_seq.
`timescale 1ns / 1ps
`default_nettype none

module gnt_mul (
    input  wire logic               aclk,
    input  wire logic signed [34:0] op_a,
    input  wire logic signed [32:0] op_b,
    output logic signed [67:0]      prod
);

    logic signed [67:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[design/gnt_seq.sv]
// Sequencer for the nudge rotation chain: angle reduction, sine/cosine
// series and plane rotations, all products through the shared gnt_mul.
// Uses gnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gnt_seq import gnt_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gnt_cmd_t           cmd,
    input  wire gnt_ang_t           ang,
    input  wire logic signed [31:0] nudge_x,
    input  wire logic signed [31:0] nudge_y,
    input  wire logic signed [31:0] nudge_z,
    output logic                    done,
    output logic signed [33:0]      delta_0,
    output logic signed [33:0]      delta_1,
    output logic signed [33:0]      delta_2,
    output logic signed [34:0]      mul_a,
    output logic signed [32:0]      mul_b,
    input  wire logic signed [67:0] mul_p
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LOAD = 5'd1;
    localparam logic [4:0] S_RED  = 5'd2;
    localparam logic [4:0] S_FOLD = 5'd3;
    localparam logic [4:0] S_XM   = 5'd4;
    localparam logic [4:0] S_XD   = 5'd5;
    localparam logic [4:0] S_XDIV = 5'd6;
    localparam logic [4:0] S_X2M  = 5'd7;
    localparam logic [4:0] S_X2R  = 5'd8;
    localparam logic [4:0] S_HM1  = 5'd9;
    localparam logic [4:0] S_HM2  = 5'd10;
    localparam logic [4:0] S_HM3  = 5'd11;
    localparam logic [4:0] S_HC   = 5'd12;
    localparam logic [4:0] S_SM   = 5'd13;
    localparam logic [4:0] S_SR   = 5'd14;
    localparam logic [4:0] S_RM1  = 5'd15;
    localparam logic [4:0] S_RM2  = 5'd16;
    localparam logic [4:0] S_RM3  = 5'd17;
    localparam logic [4:0] S_RM4  = 5'd18;
    localparam logic [4:0] S_RW   = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    logic [4:0]         state_reg;
    logic [2:0]         rot_reg;
    logic               to_origin_reg;
    logic signed [33:0] vx_reg, vy_reg, vz_reg;
    logic [32:0]        red_reg;
    logic [1:0]         quad_reg;
    logic [4:0]         cnt_reg;
    logic [21:0]        frac_reg;
    logic               swap_reg;
    logic [29:0]        x_reg, x2_reg, p_reg, qe_reg;
    logic [3:0]         hk_reg;
    logic [30:0]        t_reg, ts_reg;
    logic signed [31:0] sin_reg, cos_reg;
    logic signed [67:0] acc_reg;
    logic signed [33:0] na_reg;

    logic signed [32:0] ang_sel;
    logic signed [33:0] ang_ofs;
    logic signed [33:0] va, vb;
    logic [32:0]        red_step;
    logic               red_ge;
    logic [22:0]        fold_f;
    logic [48:0]        xsum;
    logic [29:0]        p_hi;
    logic [7:0]         hdiv;
    logic [29:0]        hrem;
    logic               hge;
    logic [30:0]        q_full, t_next;
    logic [60:0]        rsq;
    logic [30:0]        ss, cc;
    logic signed [31:0] ss_s, cc_s, sin_next, cos_next;
    logic signed [67:0] half68, rdiff, rsum;

    always_comb begin
        case (rot_reg)
            ROT_TWEAK_X: ang_sel = ang.tweak_x;
            ROT_TWEAK_Y: ang_sel = ang.tweak_y;
            ROT_TWEAK_Z: ang_sel = ang.tweak_z;
            ROT_OMEGA:   ang_sel = ang.omega;
            ROT_CHI:     ang_sel = ang.chi;
            default:     ang_sel = ang.phi;
        endcase
        case (rot_reg)
            ROT_TWEAK_Y: begin va = vz_reg; vb = vx_reg; end
            ROT_TWEAK_Z: begin va = vx_reg; vb = vy_reg; end
            ROT_CHI:     begin va = vy_reg; vb = vx_reg; end
            default:     begin va = vy_reg; vb = vz_reg; end
        endcase
    end

    assign ang_ofs  = {ang_sel[32], ang_sel} + $signed({1'b0, RED_OFS});
    assign red_step = red_div(cnt_reg[3:0]);
    assign red_ge   = red_reg >= red_step;
    assign fold_f   = red_reg[22:0];
    assign xsum     = acc_reg[48:0] + {31'd0, X_RND} + {27'd0, mul_p[53:32]};
    assign p_hi     = mul_p[59:30];
    assign hdiv     = horner_div(hk_reg);
    assign hrem     = p_reg - mul_p[29:0];
    assign hge      = hrem >= {22'd0, hdiv};
    assign q_full   = {1'b0, qe_reg} + {30'd0, hge};
    assign t_next   = ONE_Q30 - q_full;
    assign rsq      = mul_p[60:0] + {31'd0, HALF_Q30};

    assign ss   = swap_reg ? t_reg : rsq[60:30];
    assign cc   = swap_reg ? rsq[60:30] : t_reg;
    assign ss_s = $signed({1'b0, ss});
    assign cc_s = $signed({1'b0, cc});

    always_comb begin
        case (quad_reg)
            2'd0:    begin sin_next = ss_s;  cos_next = cc_s;  end
            2'd1:    begin sin_next = cc_s;  cos_next = -ss_s; end
            2'd2:    begin sin_next = -ss_s; cos_next = -cc_s; end
            default: begin sin_next = -cc_s; cos_next = ss_s;  end
        endcase
    end

    assign half68 = $signed({38'd0, HALF_Q30});
    assign rdiff  = acc_reg - mul_p + half68;
    assign rsum   = acc_reg + mul_p + half68;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_XM:  begin mul_a = {13'd0, frac_reg}; mul_b = {6'd0, PI_DIV45}; end
            S_XD:  begin mul_a = {13'd0, frac_reg}; mul_b = {1'b0, PI_REM_RCP}; end
            S_X2M: begin mul_a = {5'd0, x_reg};     mul_b = {3'd0, x_reg}; end
            S_HM1: begin mul_a = {5'd0, x2_reg};    mul_b = {2'd0, t_reg}; end
            S_HM2: begin mul_a = {5'd0, p_hi};      mul_b = {3'd0, horner_recip(hk_reg)}; end
            S_HM3: begin mul_a = {5'd0, p_hi};      mul_b = {25'd0, hdiv}; end
            S_SM:  begin mul_a = {5'd0, x_reg};     mul_b = {2'd0, ts_reg}; end
            S_RM1: begin mul_a = {va[33], va};      mul_b = {cos_reg[31], cos_reg}; end
            S_RM2: begin mul_a = {vb[33], vb};      mul_b = {sin_reg[31], sin_reg}; end
            S_RM3: begin mul_a = {va[33], va};      mul_b = {sin_reg[31], sin_reg}; end
            S_RM4: begin mul_a = {vb[33], vb};      mul_b = {cos_reg[31], cos_reg}; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rot_reg   <= ROT_TWEAK_X;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd.start) begin
                        vx_reg        <= {{2{nudge_x[31]}}, nudge_x};
                        vy_reg        <= {{2{nudge_y[31]}}, nudge_y};
                        vz_reg        <= {{2{nudge_z[31]}}, nudge_z};
                        to_origin_reg <= cmd.to_origin;
                        rot_reg       <= ROT_TWEAK_X;
                        state_reg     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    red_reg   <= ang_ofs[32:0];
                    cnt_reg   <= RED_STEPS;
                    state_reg <= S_RED;
                end
                S_RED: begin
                    if (red_ge) begin
                        red_reg <= red_reg - red_step;
                    end
                    quad_reg <= {quad_reg[0], red_ge};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (fold_f > D45) begin
                        frac_reg <= 22'(D90 - fold_f);
                        swap_reg <= 1'b1;
                    end else begin
                        frac_reg <= fold_f[21:0];
                        swap_reg <= 1'b0;
                    end
                    state_reg <= S_XM;
                end
                S_XM: begin
                    state_reg <= S_XD;
                end
                S_XD: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_XDIV;
                end
                S_XDIV: begin
                    x_reg     <= xsum[47:18];
                    state_reg <= S_X2M;
                end
                S_X2M: begin
                    state_reg <= S_X2R;
                end
                S_X2R: begin
                    x2_reg    <= rsq[59:30];
                    t_reg     <= ONE_Q30;
                    hk_reg    <= 4'd0;
                    state_reg <= S_HM1;
                end
                S_HM1: begin
                    state_reg <= S_HM2;
                end
                S_HM2: begin
                    p_reg     <= p_hi;
                    state_reg <= S_HM3;
                end
                S_HM3: begin
                    qe_reg    <= p_hi;
                    state_reg <= S_HC;
                end
                S_HC: begin
                    if (hk_reg == HK_SIN_LAST) begin
                        ts_reg <= t_next;
                        t_reg  <= ONE_Q30;
                    end else begin
                        t_reg <= t_next;
                    end
                    if (hk_reg == HK_COS_LAST) begin
                        state_reg <= S_SM;
                    end else begin
                        hk_reg    <= hk_reg + 4'd1;
                        state_reg <= S_HM1;
                    end
                end
                S_SM: begin
                    state_reg <= S_SR;
                end
                S_SR: begin
                    sin_reg   <= sin_next;
                    cos_reg   <= cos_next;
                    state_reg <= S_RM1;
                end
                S_RM1: begin
                    state_reg <= S_RM2;
                end
                S_RM2: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_RM3;
                end
                S_RM3: begin
                    na_reg    <= rdiff[63:30];
                    state_reg <= S_RM4;
                end
                S_RM4: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_RW;
                end
                S_RW: begin
                    case (rot_reg)
                        ROT_TWEAK_Y: begin vz_reg <= na_reg;  vx_reg <= rsum[63:30]; end
                        ROT_TWEAK_Z: begin vx_reg <= na_reg;  vy_reg <= rsum[63:30]; end
                        ROT_CHI:     begin vy_reg <= -na_reg; vx_reg <= rsum[63:30]; end
                        default:     begin vy_reg <= na_reg;  vz_reg <= rsum[63:30]; end
                    endcase
                    if ((rot_reg == ROT_OMEGA && to_origin_reg) || rot_reg == ROT_PHI) begin
                        state_reg <= S_DONE;
                    end else begin
                        rot_reg   <= rot_reg + 3'd1;
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE: begin
                    if (cmd.ack) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = state_reg == S_DONE;
    assign delta_0 = vy_reg;
    assign delta_1 = to_origin_reg ? vz_reg : -vz_reg;
    assign delta_2 = to_origin_reg ? vx_reg : -vx_reg;

endmodule

`default_nettype wire

[design/goniometer_nudge_transform_core.sv]
// Goniometer pose keeper with nudge transform. Mode 0 and 1 requests load the pose
// or omega in the cycle they are taken and give no result. A nudge request (mode 2
// holder, 3 origin) runs from accept to result as six (holder) or four (origin)
// rotations, and its result waits for a free output. Each rotation runs through
// one shared 35x33 multiplier, a 10-step angle reduction, a
// reciprocal divide by 45 and two Horner series with 11 reciprocal divisions in all.
// The input is not ready while a nudge is in progress. Uses gnt_pkg, gnt_mul, gnt_seq.
`timescale 1ns / 1ps
`default_nettype none

module goniometer_nudge_transform_core import gnt_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [25:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // val_x, val_y, val_z, chi_in, phi_in, origin_x_in, origin_y_in,
    // origin_z_in, omega_in (32 bits each)
    input  wire logic [287:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // holder_x, holder_y, holder_z, omega_out, chi_out, phi_out,
    // origin_x, origin_y, origin_z (32 bits each)
    output logic [287:0]      m_axis_tdata
);

    logic signed [25:0] omega_offset_reg, tweak_x_reg, tweak_y_reg, tweak_z_reg;
    logic signed [31:0] holder_x_reg, holder_y_reg, holder_z_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [31:0] omega_reg, chi_reg, phi_reg;
    logic               busy_reg;
    logic               to_origin_reg;
    logic               m_valid_reg;
    logic [287:0]       m_data_reg;

    logic               s_accept, ack, done;
    gnt_cmd_t           cmd;
    gnt_ang_t           ang;
    logic signed [33:0] delta_0, delta_1, delta_2;
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] mul_p;
    logic signed [31:0] pos_0, pos_1, pos_2;
    logic signed [31:0] new_0, new_1, new_2;
    logic signed [31:0] nh_x, nh_y, nh_z, no_x, no_y, no_z;

    assign s_axis_tready = !busy_reg;
    assign s_accept      = s_axis_tvalid && !busy_reg;
    assign ack           = done && (!m_valid_reg || m_axis_tready);

    assign cmd.start     = s_accept && s_axis_tuser[1];
    assign cmd.to_origin = s_axis_tuser == MODE_NUDGE_ORIGIN;
    assign cmd.ack       = ack;

    assign ang.tweak_x = {{7{tweak_x_reg[25]}}, tweak_x_reg};
    assign ang.tweak_y = {{7{tweak_y_reg[25]}}, tweak_y_reg};
    assign ang.tweak_z = {{7{tweak_z_reg[25]}}, tweak_z_reg};
    assign ang.omega   = {omega_reg[31], omega_reg}
                       + {{7{omega_offset_reg[25]}}, omega_offset_reg};
    assign ang.chi     = {chi_reg[31], chi_reg};
    assign ang.phi     = {phi_reg[31], phi_reg};

    gnt_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    gnt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .ang     (ang),
        .nudge_x (s_axis_tdata[31:0]),
        .nudge_y (s_axis_tdata[63:32]),
        .nudge_z (s_axis_tdata[95:64]),
        .done    (done),
        .delta_0 (delta_0),
        .delta_1 (delta_1),
        .delta_2 (delta_2),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_p   (mul_p)
    );

    assign pos_0 = to_origin_reg ? origin_x_reg : holder_x_reg;
    assign pos_1 = to_origin_reg ? origin_y_reg : holder_y_reg;
    assign pos_2 = to_origin_reg ? origin_z_reg : holder_z_reg;
    assign new_0 = sat32({{3{pos_0[31]}}, pos_0} + {delta_0[33], delta_0});
    assign new_1 = sat32({{3{pos_1[31]}}, pos_1} + {delta_1[33], delta_1});
    assign new_2 = sat32({{3{pos_2[31]}}, pos_2} + {delta_2[33], delta_2});

    assign nh_x = to_origin_reg ? holder_x_reg : new_0;
    assign nh_y = to_origin_reg ? holder_y_reg : new_1;
    assign nh_z = to_origin_reg ? holder_z_reg : new_2;
    assign no_x = to_origin_reg ? new_0 : origin_x_reg;
    assign no_y = to_origin_reg ? new_1 : origin_y_reg;
    assign no_z = to_origin_reg ? new_2 : origin_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omega_offset_reg <= '0;
            tweak_x_reg      <= '0;
            tweak_y_reg      <= '0;
            tweak_z_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OMEGA_OFFSET: omega_offset_reg <= cfg_wdata;
                REG_TWEAK_X:      tweak_x_reg      <= cfg_wdata;
                REG_TWEAK_Y:      tweak_y_reg      <= cfg_wdata;
                REG_TWEAK_Z:      tweak_z_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holder_x_reg <= '0;
            holder_y_reg <= '0;
            holder_z_reg <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            omega_reg    <= '0;
            chi_reg      <= '0;
            phi_reg      <= '0;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                unique case (s_axis_tuser)
                    MODE_SET_POSE: begin
                        holder_x_reg <= s_axis_tdata[31:0];
                        holder_y_reg <= s_axis_tdata[63:32];
                        holder_z_reg <= s_axis_tdata[95:64];
                        chi_reg      <= s_axis_tdata[127:96];
                        phi_reg      <= s_axis_tdata[159:128];
                        origin_x_reg <= s_axis_tdata[191:160];
                        origin_y_reg <= s_axis_tdata[223:192];
                        origin_z_reg <= s_axis_tdata[255:224];
                    end
                    MODE_SET_OMEGA: begin
                        omega_reg <= s_axis_tdata[287:256];
                    end
                    MODE_NUDGE_HOLDER, MODE_NUDGE_ORIGIN: begin
                        busy_reg      <= 1'b1;
                        to_origin_reg <= s_axis_tuser == MODE_NUDGE_ORIGIN;
                    end
                    default: ;
                endcase
            end
            if (ack) begin
                holder_x_reg <= nh_x;
                holder_y_reg <= nh_y;
                holder_z_reg <= nh_z;
                origin_x_reg <= no_x;
                origin_y_reg <= no_y;
                origin_z_reg <= no_z;
                busy_reg     <= 1'b0;
                m_valid_reg  <= 1'b1;
                m_data_reg   <= {no_z, no_y, no_x, phi_reg, chi_reg, omega_reg,
                                 nh_z, nh_y, nh_x};
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

[verif/goniometer_nudge_transform_core_test.sv]
// Testbench for goniometer_nudge_transform_core: directed table then random requests,
// each nudge result checked field by field against an in-bench fixed-point predictor.
// Depends on gnt_pkg and the core RTL.
`timescale 1ns / 1ps

module goniometer_nudge_transform_core_test;
    import gnt_pkg::*;

    localparam longint ONE = 64'sd1073741824;
    localparam longint HALF = 64'sd536870912;
    localparam longint PIQ = 64'sd3373259426;
    localparam longint A180 = 64'sd11796480;
    localparam longint A90 = 64'sd5898240;
    localparam longint A45 = 64'sd2949120;
    localparam longint A360 = 64'sd23592960;
    localparam int CFG_MAX = 23592960;

    typedef struct {
        logic [1:0] mode;
        logic [31:0] f[9];
    } pose_req_t;

    typedef struct {
        logic [31:0] f[9];
    } pose_t;

    typedef struct {
        logic [1:0] mode;
        logic [31:0] f[9];
        bit has_exp;
        logic [31:0] e[9];
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [25:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;

    goniometer_nudge_transform_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    longint ofs_q, twx_q, twy_q, twz_q;
    longint holder_q[3], origin_q[3];
    longint omega_q, chi_q, phi_q;
    pose_t pose_queue[$];
    int errors = 0;
    bit idle_free = 1'b0;
    int nudges_seen = 0;

    function automatic longint rnd30(longint v);
        longint w;
        w = v + HALF;
        if (w >= 0) return w >>> 30;
        return -((-w + ONE - 1) >>> 30);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint series(longint x2, bit cosine);
        longint t;
        int divs[6];
        int n;
        t = ONE;
        if (cosine) begin
            divs = '{132, 90, 56, 30, 12, 2};
            n = 6;
        end else begin
            divs = '{110, 72, 42, 20, 6, 0};
            n = 5;
        end
        for (int i = 0; i < n; i++) t = ONE - ((x2 * t) >>> 30) / divs[i];
        return t;
    endfunction

    task automatic octant_trig(input longint f, output longint s, output longint c);
        longint x, x2;
        x = (f * PIQ + A180 / 2) / A180;
        x2 = (x * x + HALF) >>> 30;
        s = (x * series(x2, 1'b0) + HALF) >>> 30;
        c = series(x2, 1'b1);
    endtask

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint r, f, ss, cc;
        int q;
        r = ang % A360;
        if (r < 0) r += A360;
        q = int'(r / A90);
        f = r % A90;
        if (f <= A45) octant_trig(f, ss, cc);
        else octant_trig(A90 - f, cc, ss);
        case (q)
            0: begin s = ss; c = cc; end
            1: begin s = cc; c = -ss; end
            2: begin s = -ss; c = -cc; end
            default: begin s = -cc; c = ss; end
        endcase
    endtask

    task automatic turn(input longint ang, inout longint a, inout longint b);
        longint s, c, na;
        sin_cos(ang, s, c);
        na = rnd30(c * a - s * b);
        b = rnd30(s * a + c * b);
        a = na;
    endtask

    task automatic apply_pose_req(input pose_req_t r);
        longint x, y, z, a, b, cc, m, p;
        pose_t res;
        case (r.mode)
            MODE_SET_POSE: begin
                for (int i = 0; i < 3; i++) begin
                    holder_q[i] = longint'($signed(r.f[i]));
                    origin_q[i] = longint'($signed(r.f[5 + i]));
                end
                chi_q = longint'($signed(r.f[3]));
                phi_q = longint'($signed(r.f[4]));
            end
            MODE_SET_OMEGA: omega_q = longint'($signed(r.f[8]));
            default: begin
                x = $signed(r.f[0]);
                y = $signed(r.f[1]);
                z = $signed(r.f[2]);
                turn(twx_q, y, z);
                turn(twy_q, z, x);
                turn(twz_q, x, y);
                a = y;
                b = z;
                cc = x;
                turn(omega_q + ofs_q, a, b);
                if (r.mode == MODE_NUDGE_ORIGIN) begin
                    origin_q[0] = clamp32(origin_q[0] + a);
                    origin_q[1] = clamp32(origin_q[1] + b);
                    origin_q[2] = clamp32(origin_q[2] + cc);
                end else begin
                    m = a;
                    turn(chi_q, m, cc);
                    p = -m;
                    turn(phi_q, p, b);
                    holder_q[0] = clamp32(holder_q[0] + p);
                    holder_q[1] = clamp32(holder_q[1] - b);
                    holder_q[2] = clamp32(holder_q[2] - cc);
                end
                res.f[0] = holder_q[0][31:0];
                res.f[1] = holder_q[1][31:0];
                res.f[2] = holder_q[2][31:0];
                res.f[3] = omega_q[31:0];
                res.f[4] = chi_q[31:0];
                res.f[5] = phi_q[31:0];
                res.f[6] = origin_q[0][31:0];
                res.f[7] = origin_q[1][31:0];
                res.f[8] = origin_q[2][31:0];
                pose_queue.push_back(res);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[25:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OMEGA_OFFSET: ofs_q = v;
            REG_TWEAK_X: twx_q = v;
            REG_TWEAK_Y: twy_q = v;
            default: twz_q = v;
        endcase
    endtask

    task automatic wait_drained();
        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_req(input pose_req_t r);
        @(posedge aclk);
        while (!idle_free && $urandom_range(99) < 31) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.mode;
        for (int i = 0; i < 9; i++) s_axis_tdata[32 * i +: 32] <= r.f[i];
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        apply_pose_req(r);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word(int kind);
        case (kind)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(2 * 3276800)) - 3276800;
        endcase
    endfunction

    function automatic int rand_cfg();
        case ($urandom_range(5))
            0: return CFG_MAX;
            1: return -CFG_MAX;
            2: return 0;
            default: return int'($urandom_range(2 * CFG_MAX)) - CFG_MAX;
        endcase
    endfunction

    // result side: random stalls and compare against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pose_queue.size() == 0) begin
                    report_mismatch("pose result with none expected");
                end else begin
                    pose_t e;
                    e = pose_queue.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (m_axis_tdata[32 * i +: 32] !== e.f[i])
                            report_mismatch($sformatf("field %0d got %h want %h",
                                i, m_axis_tdata[32 * i +: 32], e.f[i]));
                    end
                end
                nudges_seen++;
            end
            m_axis_tready <= idle_free || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t d;
        pose_req_t r;
        pose_t got_unused;
        ofs_q = 0; twx_q = 0; twy_q = 0; twz_q = 0;
        omega_q = 0; chi_q = 0; phi_q = 0;
        for (int i = 0; i < 3; i++) begin
            holder_q[i] = 0;
            origin_q[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // zero angles: nudge passes straight through, origin gains (y, z, x)
        d.has_exp = 1'b1;
        d.mode = MODE_NUDGE_ORIGIN;
        d.f = '{32'd100, 32'd200, 32'd300, 0, 0, 0, 0, 0, 0};
        d.e = '{0, 0, 0, 0, 0, 0, 32'd200, 32'd300, 32'd100};
        rows.push_back(d);
        // saturate the origin at the top and at the bottom
        d.mode = MODE_SET_POSE;
        d.f = '{0, 0, 0, 0, 0, 32'h7FFF_FFF0, 32'h8000_0010, 32'h7FFF_FFFF, 0};
        d.has_exp = 1'b0;
        rows.push_back(d);
        d.mode = MODE_NUDGE_ORIGIN;
        d.f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0};
        d.has_exp = 1'b1;
        d.e = '{0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        rows.push_back(d);
        d.has_exp = 1'b0;
        for (int k = 0; k < 16; k++) begin
            d.mode = k[1:0];
            for (int i = 0; i < 9; i++) d.f[i] = rand_word((k + i) % 4);
            rows.push_back(d);
        end
        foreach (rows[j]) begin
            r.mode = rows[j].mode;
            r.f = rows[j].f;
            if (rows[j].has_exp) begin
                wait_drained();
                send_req(r);
                got_unused.f = rows[j].e;
                if (pose_queue.size() != 0 && pose_queue[$].f != got_unused.f)
                    report_mismatch($sformatf("directed row %0d prediction", j));
            end else begin
                send_req(r);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            for (int g = 0; g < 4; g++) begin
                case (ph)
                    0: write_reg(g[1:0], CFG_MAX);
                    1: write_reg(g[1:0], -CFG_MAX);
                    2: write_reg(g[1:0], 0);
                    default: write_reg(g[1:0], rand_cfg());
                endcase
            end
            idle_free = (ph == 3);
            for (int k = 0; k < 200; k++) begin
                case ($urandom_range(9))
                    0, 1: r.mode = MODE_SET_POSE;
                    2, 3: r.mode = MODE_SET_OMEGA;
                    4, 5, 6: r.mode = MODE_NUDGE_HOLDER;
                    default: r.mode = MODE_NUDGE_ORIGIN;
                endcase
                for (int i = 0; i < 9; i++) begin
                    int kind;
                    kind = $urandom_range(9);
                    r.f[i] = rand_word(kind < 1 ? 0 : kind < 2 ? 1 : kind < 5 ? 2 : 3);
                end
                send_req(r);
            end
        end
        idle_free = 1'b0;

        wait_drained();
        repeat (700) @(posedge aclk);
        if (errors == 0 && pose_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
design/gnt_pkg.sv
design/gnt_mul.sv
design/gnt_seq.sv
design/goniometer_nudge_transform_core.sv
verif/goniometer_nudge_transform_core_test.sv
